// ===== hdl/accmd_pkg.sv =====
// Package for the accelerometer motion detector: field widths, register map,
// reset values and the types shared by the lanes, the merge stage and the top level.
// Depends on nothing.
package accmd_pkg;

	localparam int AXES     = 3;
	localparam int WORD_W   = 16;
	localparam int SAMPLE_W = 12;
	localparam int FILT_W   = 13;
	localparam int MAG_W    = 13;
	localparam int THR_W    = 16;
	localparam int SUM_W    = 17;
	localparam int ABS_W    = 16;
	localparam int PROD_W   = 32;
	localparam int OUT_W    = 16;
	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 32;

	// Divide by ten as a multiply by 2^19/10 rounded up; exact for operands up to 81919.
	localparam logic [ABS_W-1:0] RECIP10    = 16'd52429;
	localparam int               RECIP_SH   = 19;

	// Register indexes (byte address 4 * index).
	localparam logic [1:0] REG_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_OFFSET_X  = 2'd1;
	localparam logic [1:0] REG_OFFSET_Y  = 2'd2;
	localparam logic [1:0] REG_OFFSET_Z  = 2'd3;

	localparam logic [THR_W-1:0]    THRESHOLD_RST = 16'd300;
	localparam logic [SAMPLE_W-1:0] OFFSET_X_RST  = 12'sd48;
	localparam logic [SAMPLE_W-1:0] OFFSET_Y_RST  = -12'sd15;
	localparam logic [SAMPLE_W-1:0] OFFSET_Z_RST  = -12'sd1000;

	typedef logic signed [FILT_W-1:0]   filt_t;
	typedef logic signed [SAMPLE_W-1:0] offs_t;

	typedef struct packed {
		logic accept;  // sample transaction taken into stage 1
		logic update;  // stage 1 sample applied to the filter
		logic clear;   // that sample closes the window
	} lane_ctrl_t;

endpackage

// ===== hdl/accel_motion_detector.sv =====
// Top level of the accelerometer motion detector: register file, sample
// pipeline control, three axis lanes and the merge stage.
// Depends on accmd_pkg, accmd_lane and accmd_merge.

// The block takes one x/y/z sample per input transaction and can take one in
// every clock cycle while not stalled: each axis has its own lane, and the filter
// update of a lane (a multiply by nine, an add and a divide by ten done as a
// reciprocal multiply) is one combinational path into the filter register, so
// that loop allows one sample per cycle. A sample is registered with its offset
// applied in stage 1 and folded into the filters when stage 1 advances. The
// sample that completes a window of SAMPLES_PER_DECISION samples also copies the
// filter values into the merge stage and clears the filters and the counter; the
// merge stage then finds the largest magnitude and compares it with the
// threshold, and the result transaction is offered from the output register. The
// output register and the merge register each hold one result, so the input only
// stalls while a window-end sample waits in stage 1 with both of them full and
// the result not being taken. Configuration is by the APB port; writes
// should be made only while no sample is in flight.
module accel_motion_detector #(
	parameter int SAMPLES_PER_DECISION = 15
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// APB configuration port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [accmd_pkg::ADDR_W-1:0]    paddr,
	input  logic [accmd_pkg::DATA_W-1:0]    pwdata,
	output logic [accmd_pkg::DATA_W-1:0]    prdata,
	output logic                            pready,
	// Sample stream
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [3*accmd_pkg::WORD_W-1:0]  s_axis_tdata,  // x_word[15:0], y_word[31:16], z_word[47:32]
	// Result stream
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [accmd_pkg::OUT_W-1:0]     m_axis_tdata   // moving[0], largest_change[13:1], zero[15:14]
);

	localparam int CNT_W = $clog2(SAMPLES_PER_DECISION + 1);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_DECISION - 1);

	logic [accmd_pkg::THR_W-1:0]  threshold_q;
	accmd_pkg::offs_t             offset_q [accmd_pkg::AXES];
	logic                         cfg_wr;
	logic [1:0]                   cfg_idx;

	logic [CNT_W-1:0]             cnt_q;
	logic                         valid_s1;
	logic                         last_s1;
	logic                         acc_last;
	logic                         s1_adv;
	logic                         merge_rdy;
	accmd_pkg::lane_ctrl_t        lane_ctrl;
	accmd_pkg::filt_t             f_next [accmd_pkg::AXES];

	// ------------------------------------------------------------------
	// Configuration registers. Every address maps onto one of the four
	// registers by bits 3:2.
	// ------------------------------------------------------------------
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= accmd_pkg::THRESHOLD_RST;
			offset_q[0] <= accmd_pkg::OFFSET_X_RST;
			offset_q[1] <= accmd_pkg::OFFSET_Y_RST;
			offset_q[2] <= accmd_pkg::OFFSET_Z_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				accmd_pkg::REG_THRESHOLD: threshold_q <= pwdata[accmd_pkg::THR_W-1:0];
				accmd_pkg::REG_OFFSET_X:  offset_q[0] <= pwdata[accmd_pkg::SAMPLE_W-1:0];
				accmd_pkg::REG_OFFSET_Y:  offset_q[1] <= pwdata[accmd_pkg::SAMPLE_W-1:0];
				accmd_pkg::REG_OFFSET_Z:  offset_q[2] <= pwdata[accmd_pkg::SAMPLE_W-1:0];
				default: ;
			endcase
		end
	end

	// Offsets read back sign-extended, the threshold zero-extended.
	always_comb begin
		case (cfg_idx)
			accmd_pkg::REG_THRESHOLD:
				prdata = {{(accmd_pkg::DATA_W-accmd_pkg::THR_W){1'b0}}, threshold_q};
			accmd_pkg::REG_OFFSET_X:
				prdata = accmd_pkg::DATA_W'(offset_q[0]);
			accmd_pkg::REG_OFFSET_Y:
				prdata = accmd_pkg::DATA_W'(offset_q[1]);
			accmd_pkg::REG_OFFSET_Z:
				prdata = accmd_pkg::DATA_W'(offset_q[2]);
			default:
				prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Pipeline control. A stage 1 sample that does not close a window
	// always moves on; one that does needs room in the merge stage.
	// ------------------------------------------------------------------
	assign s1_adv        = !valid_s1 || !last_s1 || merge_rdy;
	assign s_axis_tready = s1_adv;
	assign acc_last      = (cnt_q == CNT_LAST);

	assign lane_ctrl.accept = s_axis_tvalid && s_axis_tready;
	assign lane_ctrl.update = valid_s1 && s1_adv;
	assign lane_ctrl.clear  = last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (lane_ctrl.accept) begin
				valid_s1 <= 1'b1;
				last_s1  <= acc_last;
				cnt_q    <= acc_last ? '0 : cnt_q + 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Axis lanes and the merge stage.
	// ------------------------------------------------------------------
	for (genvar a = 0; a < accmd_pkg::AXES; a++) begin : g_lane
		accmd_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (lane_ctrl),
			.word   (s_axis_tdata[a*accmd_pkg::WORD_W +: accmd_pkg::WORD_W]),
			.offset (offset_q[a]),
			.f_next (f_next[a])
		);
	end

	accmd_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (lane_ctrl.update && lane_ctrl.clear),
		.f_in      (f_next),
		.threshold (threshold_q),
		.ready     (merge_rdy),
		.m_tvalid  (m_axis_tvalid),
		.m_tready  (m_axis_tready),
		.m_tdata   (m_axis_tdata)
	);

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------

	// The sample counter never reaches the window length.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_LAST)
		else $error("window counter out of range");

	// Accepting the window-closing sample restarts the count.
	a_cnt_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		lane_ctrl.accept && acc_last |=> cnt_q == '0 && last_s1 && valid_s1)
		else $error("window counter did not restart");

	// A window-end filter update is never applied while the merge stage is full.
	a_merge_room: assert property (@(posedge clk) disable iff (!arst_n)
		lane_ctrl.update && lane_ctrl.clear |-> merge_rdy)
		else $error("window result overwrote a pending result");

endmodule

// ===== hdl/accmd_lane.sv =====
// One axis lane of the motion detector: sample extraction, offset and the
// decimal smoothing filter. Depends on accmd_pkg.
module accmd_lane (
	input  logic                       clk,
	input  logic                       arst_n,
	input  accmd_pkg::lane_ctrl_t      ctrl,
	input  logic [accmd_pkg::WORD_W-1:0] word,
	input  accmd_pkg::offs_t           offset,
	output accmd_pkg::filt_t           f_next
);

	logic signed [accmd_pkg::SAMPLE_W-1:0] sample;
	logic signed [accmd_pkg::FILT_W-1:0]   d_next;
	logic signed [accmd_pkg::FILT_W-1:0]   d_s1;
	accmd_pkg::filt_t                      f_q;
	logic signed [accmd_pkg::SUM_W-1:0]    nine_f;
	logic signed [accmd_pkg::SUM_W-1:0]    sum;
	logic signed [accmd_pkg::SUM_W-1:0]    sum_neg;
	logic [accmd_pkg::ABS_W-1:0]           sum_mag;
	logic [accmd_pkg::PROD_W-1:0]          prod;
	logic [accmd_pkg::FILT_W:0]            quot;
	logic [accmd_pkg::FILT_W:0]            quot_neg;

	// The sample is left aligned; the low nibble is padding.
	assign sample = word[accmd_pkg::WORD_W-1 -: accmd_pkg::SAMPLE_W];
	assign d_next = {sample[accmd_pkg::SAMPLE_W-1], sample}
		+ {offset[accmd_pkg::SAMPLE_W-1], offset};

	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			d_s1 <= d_next;
		end
	end

	// f = trunc((d + 9f) / 10): divide the magnitude, then restore the sign.
	always_comb begin
		nine_f   = (accmd_pkg::SUM_W'(f_q) <<< 3) + accmd_pkg::SUM_W'(f_q);
		sum      = accmd_pkg::SUM_W'(d_s1) + nine_f;
		sum_neg  = -sum;
		sum_mag  = sum[accmd_pkg::SUM_W-1] ? sum_neg[accmd_pkg::ABS_W-1:0]
			: sum[accmd_pkg::ABS_W-1:0];
		prod     = {{(accmd_pkg::PROD_W-accmd_pkg::ABS_W){1'b0}}, sum_mag}
			* {{(accmd_pkg::PROD_W-accmd_pkg::ABS_W){1'b0}}, accmd_pkg::RECIP10};
		quot     = {1'b0, prod[accmd_pkg::RECIP_SH +: accmd_pkg::FILT_W]};
		quot_neg = '0 - quot;
		f_next   = sum[accmd_pkg::SUM_W-1] ? quot_neg[accmd_pkg::FILT_W-1:0]
			: quot[accmd_pkg::FILT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_q <= '0;
		end else if (ctrl.update) begin
			f_q <= ctrl.clear ? '0 : f_next;
		end
	end

endmodule

// ===== hdl/accmd_merge.sv =====
// Merge stage of the motion detector: holds the window-end filter values,
// picks the largest magnitude, compares it with the threshold and drives the
// result register. Depends on accmd_pkg.
module accmd_merge (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  accmd_pkg::filt_t              f_in [accmd_pkg::AXES],
	input  logic [accmd_pkg::THR_W-1:0]   threshold,
	output logic                          ready,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [accmd_pkg::OUT_W-1:0]   m_tdata
);

	accmd_pkg::filt_t              f_s2 [accmd_pkg::AXES];
	logic                          valid_s2;
	logic [accmd_pkg::MAG_W-1:0]   mag [accmd_pkg::AXES];
	logic [accmd_pkg::MAG_W-1:0]   largest;
	logic [accmd_pkg::FILT_W-1:0]  f_neg;
	logic                          out_free;
	logic                          m_tvalid_q;
	logic                          moving_q;
	logic [accmd_pkg::MAG_W-1:0]   largest_q;

	assign out_free = !m_tvalid_q || m_tready;
	assign ready    = !valid_s2 || out_free;

	always_ff @(posedge clk) begin
		if (load) begin
			f_s2 <= f_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (out_free) begin
			valid_s2 <= 1'b0;
		end
	end

	// A filter value of -4096 has magnitude 4096, which the unsigned field still holds.
	always_comb begin
		largest = '0;
		f_neg   = '0;
		for (int i = 0; i < accmd_pkg::AXES; i++) begin
			f_neg  = '0 - f_s2[i];
			mag[i] = f_s2[i][accmd_pkg::FILT_W-1] ? f_neg : f_s2[i];
			if (mag[i] > largest) begin
				largest = mag[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && out_free) begin
			largest_q <= largest;
			moving_q  <= {{(accmd_pkg::THR_W-accmd_pkg::MAG_W){1'b0}}, largest} > threshold;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_free) begin
			m_tvalid_q <= valid_s2;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(accmd_pkg::OUT_W-accmd_pkg::MAG_W-1){1'b0}}, largest_q, moving_q};

endmodule
